>>> design/rsi_pkg.sv
package rsi_pkg;

  // coordinate format
  localparam int CW        = 32;
  localparam int FB        = 16;
  localparam int DW        = CW - 1;
  localparam int MIN_W     = 16;
  localparam int MIN_RESET = 1;

  // quadratic coefficient widths
  localparam int LW    = CW + 1;
  localparam int DD_W  = 2 * CW;
  localparam int DL_W  = 2 * CW + 1;
  localparam int LL_W  = 2 * CW + 2;
  localparam int RR_W  = 2 * DW;
  localparam int A_W   = 2 * CW;
  localparam int HB_W  = 2 * CW + 3;
  localparam int C_W   = 2 * CW + 4;
  localparam int HBM_W = 2 * CW + 1;
  localparam int CM_W  = 2 * CW + 2;

  // partial product widths
  localparam int HH_W  = HBM_W - CW;
  localparam int AH_W  = A_W - CW;
  localparam int CH_W  = CM_W - CW;
  localparam int PHH_W = 2 * HH_W;
  localparam int PHM_W = HH_W + CW;
  localparam int PLL_W = 2 * CW;
  localparam int QLH_W = CW + CH_W;
  localparam int QHL_W = AH_W + CW;
  localparam int QHH_W = AH_W + CH_W;
  localparam int M1_W  = MIN_W + 1;
  localparam int T_W   = M1_W + CW;
  localparam int THR_W = A_W + M1_W;
  localparam int HB2_W = 2 * HBM_W;
  localparam int DISC_W = HB2_W + 2;

  // root and division widths
  localparam int S_W   = 2 * CW + 2 + FB;
  localparam int X_W   = 2 * S_W;
  localparam int REM_W = S_W + 2;
  localparam int NUM_W = HB_W + FB + 2;
  localparam int RW    = A_W + DW;

  localparam int QD_DEPTH = 7;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [DW-1:0]        sphere_radius;
  } rsi_ray_t;

  typedef struct packed {
    logic [A_W-1:0]          a;
    logic signed [HB_W-1:0]  hb;
    logic [THR_W-1:0]        thr;
    logic                    root_ok;
  } rsi_side_t;

  typedef struct packed {
    logic hit;
    logic sat;
  } rsi_flag_t;

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] distance;
  } rsi_res_t;

endpackage

>>> design/rsi_if.sv
interface rsi_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [rsi_pkg::CW-1:0] origin_x;
  logic signed [rsi_pkg::CW-1:0] origin_y;
  logic signed [rsi_pkg::CW-1:0] origin_z;
  logic signed [rsi_pkg::CW-1:0] dir_x;
  logic signed [rsi_pkg::CW-1:0] dir_y;
  logic signed [rsi_pkg::CW-1:0] dir_z;
  logic signed [rsi_pkg::CW-1:0] center_x;
  logic signed [rsi_pkg::CW-1:0] center_y;
  logic signed [rsi_pkg::CW-1:0] center_z;
  logic [rsi_pkg::DW-1:0]        sphere_radius;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, sphere_radius, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface rsi_out_if;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [rsi_pkg::DW-1:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

interface rsi_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rsi_pkg::MIN_W-1:0] min_distance;

  modport source (output valid, min_distance, input ready);
  modport sink (input valid, min_distance, output ready);
endinterface

>>> design/rsi_quad.sv
module rsi_quad (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  rsi_pkg::rsi_ray_t         in_ray,
  input  logic [rsi_pkg::MIN_W-1:0] min_dist,
  output logic                      out_valid,
  output rsi_pkg::rsi_side_t        out_side,
  output logic [rsi_pkg::X_W-1:0]   out_x
);

  localparam int CW     = rsi_pkg::CW;
  localparam int FB     = rsi_pkg::FB;
  localparam int LW     = rsi_pkg::LW;
  localparam int DD_W   = rsi_pkg::DD_W;
  localparam int DL_W   = rsi_pkg::DL_W;
  localparam int LL_W   = rsi_pkg::LL_W;
  localparam int RR_W   = rsi_pkg::RR_W;
  localparam int A_W    = rsi_pkg::A_W;
  localparam int HB_W   = rsi_pkg::HB_W;
  localparam int C_W    = rsi_pkg::C_W;
  localparam int HBM_W  = rsi_pkg::HBM_W;
  localparam int CM_W   = rsi_pkg::CM_W;
  localparam int HH_W   = rsi_pkg::HH_W;
  localparam int AH_W   = rsi_pkg::AH_W;
  localparam int CH_W   = rsi_pkg::CH_W;
  localparam int PHH_W  = rsi_pkg::PHH_W;
  localparam int PHM_W  = rsi_pkg::PHM_W;
  localparam int PLL_W  = rsi_pkg::PLL_W;
  localparam int QLH_W  = rsi_pkg::QLH_W;
  localparam int QHL_W  = rsi_pkg::QHL_W;
  localparam int QHH_W  = rsi_pkg::QHH_W;
  localparam int M1_W   = rsi_pkg::M1_W;
  localparam int T_W    = rsi_pkg::T_W;
  localparam int THR_W  = rsi_pkg::THR_W;
  localparam int HB2_W  = rsi_pkg::HB2_W;
  localparam int DISC_W = rsi_pkg::DISC_W;
  localparam int X_W    = rsi_pkg::X_W;
  localparam int DR     = rsi_pkg::QD_DEPTH;

  logic [DR-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DR-2:0], in_valid};
    end
  end

  // stage 1: ray origin relative to sphere center
  logic signed [LW-1:0] l1_r [3];
  logic signed [LW-1:0] l1_nxt [3];
  logic signed [CW-1:0] d1_r [3];
  logic [rsi_pkg::DW-1:0] r1_r;

  always_comb begin
    l1_nxt[0] = LW'(in_ray.origin_x) - LW'(in_ray.center_x);
    l1_nxt[1] = LW'(in_ray.origin_y) - LW'(in_ray.center_y);
    l1_nxt[2] = LW'(in_ray.origin_z) - LW'(in_ray.center_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r  <= l1_nxt;
      d1_r[0] <= in_ray.dir_x;
      d1_r[1] <= in_ray.dir_y;
      d1_r[2] <= in_ray.dir_z;
      r1_r  <= in_ray.sphere_radius;
    end
  end

  // stage 2: per-axis products
  logic signed [DD_W-1:0] dd2_r [3];
  logic signed [DL_W-1:0] dl2_r [3];
  logic signed [LL_W-1:0] ll2_r [3];
  logic [RR_W-1:0]        rr2_r;
  logic signed [DD_W-1:0] dd2_nxt [3];
  logic signed [DL_W-1:0] dl2_nxt [3];
  logic signed [LL_W-1:0] ll2_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd2_nxt[i] = DD_W'(d1_r[i]) * DD_W'(d1_r[i]);
      dl2_nxt[i] = DL_W'(d1_r[i]) * DL_W'(l1_r[i]);
      ll2_nxt[i] = LL_W'(l1_r[i]) * LL_W'(l1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd2_r <= dd2_nxt;
      dl2_r <= dl2_nxt;
      ll2_r <= ll2_nxt;
      rr2_r <= RR_W'(r1_r) * RR_W'(r1_r);
    end
  end

  // stage 3: a, half b, c
  logic [A_W-1:0]         a3_r;
  logic signed [HB_W-1:0] hb3_r;
  logic signed [C_W-1:0]  c3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r  <= A_W'(dd2_r[0]) + A_W'(dd2_r[1]) + A_W'(dd2_r[2]);
      hb3_r <= HB_W'(dl2_r[0]) + HB_W'(dl2_r[1]) + HB_W'(dl2_r[2]);
      c3_r  <= C_W'(ll2_r[0]) + C_W'(ll2_r[1]) + C_W'(ll2_r[2]) - C_W'(rr2_r);
    end
  end

  // stage 4: magnitudes for the unsigned partial products
  logic [A_W-1:0]         a4_r;
  logic signed [HB_W-1:0] hb4_r;
  logic [HBM_W-1:0]       hbm4_r;
  logic [CM_W-1:0]        cm4_r;
  logic                   cn4_r;
  logic signed [HB_W-1:0] hb3_neg;
  logic signed [C_W-1:0]  c3_neg;

  assign hb3_neg = -hb3_r;
  assign c3_neg  = -c3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r   <= a3_r;
      hb4_r  <= hb3_r;
      hbm4_r <= hb3_r[HB_W-1] ? HBM_W'(hb3_neg) : HBM_W'(hb3_r);
      cm4_r  <= c3_r[C_W-1] ? CM_W'(c3_neg) : CM_W'(c3_r);
      cn4_r  <= c3_r[C_W-1];
    end
  end

  // stage 5: partial products of hb^2, a*|c| and (min+1)*a
  logic [HH_W-1:0]  hh;
  logic [CW-1:0]    hl;
  logic [AH_W-1:0]  ah;
  logic [CW-1:0]    al;
  logic [CH_W-1:0]  ch;
  logic [CW-1:0]    cl;
  logic [M1_W-1:0]  m1;

  assign hh = hbm4_r[HBM_W-1:CW];
  assign hl = hbm4_r[CW-1:0];
  assign ah = a4_r[A_W-1:CW];
  assign al = a4_r[CW-1:0];
  assign ch = cm4_r[CM_W-1:CW];
  assign cl = cm4_r[CW-1:0];
  assign m1 = M1_W'(min_dist) + M1_W'(1);

  logic [A_W-1:0]         a5_r;
  logic signed [HB_W-1:0] hb5_r;
  logic                   cn5_r;
  logic [PHH_W-1:0]       phh5_r;
  logic [PHM_W-1:0]       phm5_r;
  logic [PLL_W-1:0]       pll5_r;
  logic [PLL_W-1:0]       qll5_r;
  logic [QLH_W-1:0]       qlh5_r;
  logic [QHL_W-1:0]       qhl5_r;
  logic [QHH_W-1:0]       qhh5_r;
  logic [T_W-1:0]         tlo5_r;
  logic [T_W-1:0]         thi5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a5_r   <= a4_r;
      hb5_r  <= hb4_r;
      cn5_r  <= cn4_r;
      phh5_r <= PHH_W'(hh) * PHH_W'(hh);
      phm5_r <= PHM_W'(hh) * PHM_W'(hl);
      pll5_r <= PLL_W'(hl) * PLL_W'(hl);
      qll5_r <= PLL_W'(al) * PLL_W'(cl);
      qlh5_r <= QLH_W'(al) * QLH_W'(ch);
      qhl5_r <= QHL_W'(ah) * QHL_W'(cl);
      qhh5_r <= QHH_W'(ah) * QHH_W'(ch);
      tlo5_r <= T_W'(m1) * T_W'(al);
      thi5_r <= T_W'(m1) * T_W'(ah);
    end
  end

  // stage 6: assemble the wide products
  logic [A_W-1:0]         a6_r;
  logic signed [HB_W-1:0] hb6_r;
  logic                   cn6_r;
  logic [HB2_W-1:0]       hb2_6_r;
  logic [HB2_W-1:0]       ac6_r;
  logic [THR_W-1:0]       thr6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a6_r    <= a5_r;
      hb6_r   <= hb5_r;
      cn6_r   <= cn5_r;
      // cross term appears twice, hence one extra bit of shift
      hb2_6_r <= (HB2_W'(phh5_r) << (2 * CW)) + (HB2_W'(phm5_r) << (CW + 1))
                 + HB2_W'(pll5_r);
      ac6_r   <= (HB2_W'(qhh5_r) << (2 * CW))
                 + ((HB2_W'(qlh5_r) + HB2_W'(qhl5_r)) << CW) + HB2_W'(qll5_r);
      thr6_r  <= THR_W'(tlo5_r) + (THR_W'(thi5_r) << CW);
    end
  end

  // stage 7: quarter discriminant, radicand scaled by 2^(2*FB)
  logic [DISC_W-1:0] disc;
  logic              root_ok;

  always_comb begin
    if (cn6_r) begin
      disc = DISC_W'(hb2_6_r) + DISC_W'(ac6_r);
    end else begin
      disc = DISC_W'(hb2_6_r) - DISC_W'(ac6_r);
    end
    root_ok = (a6_r != '0) && !disc[DISC_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side.a       <= a6_r;
      out_side.hb      <= hb6_r;
      out_side.thr     <= thr6_r;
      out_side.root_ok <= root_ok;
      out_x            <= root_ok ? {1'b0, disc[DISC_W-2:0], {(2 * FB){1'b0}}} : '0;
    end
  end

  assign out_valid = v_r[DR-1];

endmodule

>>> design/rsi_sqrt.sv
module rsi_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  rsi_pkg::rsi_side_t      in_side,
  input  logic [rsi_pkg::X_W-1:0] in_x,
  output logic                    out_valid,
  output rsi_pkg::rsi_side_t      out_side,
  output logic [rsi_pkg::S_W-1:0] out_s,
  output logic                    out_exact
);

  localparam int S_W   = rsi_pkg::S_W;
  localparam int X_W   = rsi_pkg::X_W;
  localparam int REM_W = rsi_pkg::REM_W;

  logic               v_r    [S_W];
  logic [REM_W-1:0]   rem_r  [S_W];
  logic [S_W-1:0]     root_r [S_W];
  logic [X_W-1:0]     xs_r   [S_W];
  rsi_pkg::rsi_side_t side_r [S_W];

  // one result bit per stage, radicand consumed two bits at a time
  for (genvar k = 0; k < S_W; k++) begin : g_stage
    logic               v_in;
    logic [REM_W-1:0]   rem_in;
    logic [S_W-1:0]     root_in;
    logic [X_W-1:0]     xs_in;
    rsi_pkg::rsi_side_t side_in;
    logic [REM_W-1:0]   rem_t;
    logic [REM_W-1:0]   trial;
    logic [REM_W-1:0]   rem_nxt;
    logic [S_W-1:0]     root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = in_x;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign xs_in   = xs_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem_t = {rem_in[REM_W-3:0], xs_in[X_W-1 -: 2]};
      trial = {root_in, 2'b01};
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_in[S_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_in[S_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        xs_r[k]   <= xs_in << 2;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[S_W-1];
  assign out_side  = side_r[S_W-1];
  assign out_s     = root_r[S_W-1];
  assign out_exact = (rem_r[S_W-1] == '0);

endmodule

>>> design/rsi_div.sv
module rsi_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [rsi_pkg::RW-1:0]  in_num,
  input  logic [rsi_pkg::A_W-1:0] in_a,
  input  rsi_pkg::rsi_flag_t      in_flags,
  output logic                    out_valid,
  output rsi_pkg::rsi_flag_t      out_flags,
  output logic [rsi_pkg::DW-1:0]  out_q
);

  localparam int DW  = rsi_pkg::DW;
  localparam int RW  = rsi_pkg::RW;
  localparam int A_W = rsi_pkg::A_W;

  logic               v_r   [DW];
  logic [RW-1:0]      rem_r [DW];
  logic [A_W-1:0]     a_r   [DW];
  logic [DW-1:0]      q_r   [DW];
  rsi_pkg::rsi_flag_t f_r   [DW];

  // restoring division, quotient msb first; the quotient is only valid when the numerator is below a*2^DW
  for (genvar j = 0; j < DW; j++) begin : g_stage
    localparam int SH = DW - 1 - j;
    logic               v_in;
    logic [RW-1:0]      rem_in;
    logic [A_W-1:0]     a_in;
    logic [DW-1:0]      q_in;
    rsi_pkg::rsi_flag_t f_in;
    logic [RW-1:0]      dv;
    logic [RW-1:0]      rem_nxt;
    logic [DW-1:0]      q_nxt;

    if (j == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_num;
      assign a_in   = in_a;
      assign q_in   = '0;
      assign f_in   = in_flags;
    end else begin : g_next
      assign v_in   = v_r[j-1];
      assign rem_in = rem_r[j-1];
      assign a_in   = a_r[j-1];
      assign q_in   = q_r[j-1];
      assign f_in   = f_r[j-1];
    end

    always_comb begin
      dv = RW'(a_in) << SH;
      if (rem_in >= dv) begin
        rem_nxt = rem_in - dv;
        q_nxt   = {q_in[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_in;
        q_nxt   = {q_in[DW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        a_r[j]   <= a_in;
        q_r[j]   <= q_nxt;
        f_r[j]   <= f_in;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_flags = f_r[DW-1];
  assign out_q     = q_r[DW-1];

endmodule

>>> design/ray_sphere_intersect.sv
// channel   dir  fields                                          transfer when
// in_ch     in   origin_x/y/z, dir_x/y/z, center_x/y/z, radius    valid && ready
// out_ch    out  hit, hit_distance                               valid && ready
// cfg_ch    in   min_distance                                    valid && ready
//
// one ray per cycle while the skid entry is empty; from input transfer to out_ch.valid:
// 7 coefficient stages, 82 square root stages, 2 root select stages,
// 31 divider stages and the output register.
// the whole pipeline advances together while the output skid entry is empty.
// rst_n (synchronous) clears valid bits and sets min_distance to 1.
module ray_sphere_intersect (
  input logic       clk,
  input logic       rst_n,
  rsi_in_if.sink    in_ch,
  rsi_out_if.source out_ch,
  rsi_cfg_if.sink   cfg_ch
);

  localparam int DW    = rsi_pkg::DW;
  localparam int FB    = rsi_pkg::FB;
  localparam int MIN_W = rsi_pkg::MIN_W;
  localparam int A_W   = rsi_pkg::A_W;
  localparam int HB_W  = rsi_pkg::HB_W;
  localparam int THR_W = rsi_pkg::THR_W;
  localparam int S_W   = rsi_pkg::S_W;
  localparam int X_W   = rsi_pkg::X_W;
  localparam int NUM_W = rsi_pkg::NUM_W;
  localparam int RW    = rsi_pkg::RW;

  logic en;
  logic skid_v_r;
  logic skid_v_nxt;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // configuration
  logic [MIN_W-1:0] min_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_W'(rsi_pkg::MIN_RESET);
    end else if (cfg_ch.valid) begin
      min_r <= cfg_ch.min_distance;
    end
  end

  rsi_pkg::rsi_ray_t ray;

  assign ray = '{origin_x:      in_ch.origin_x,
                 origin_y:      in_ch.origin_y,
                 origin_z:      in_ch.origin_z,
                 dir_x:         in_ch.dir_x,
                 dir_y:         in_ch.dir_y,
                 dir_z:         in_ch.dir_z,
                 center_x:      in_ch.center_x,
                 center_y:      in_ch.center_y,
                 center_z:      in_ch.center_z,
                 sphere_radius: in_ch.sphere_radius};

  logic               q_valid;
  rsi_pkg::rsi_side_t q_side;
  logic [X_W-1:0]     q_x;

  rsi_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_ray    (ray),
    .min_dist  (min_r),
    .out_valid (q_valid),
    .out_side  (q_side),
    .out_x     (q_x)
  );

  logic               s_valid;
  rsi_pkg::rsi_side_t s_side;
  logic [S_W-1:0]     s_root;
  logic               s_exact;

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_side   (q_side),
    .in_x      (q_x),
    .out_valid (s_valid),
    .out_side  (s_side),
    .out_s     (s_root),
    .out_exact (s_exact)
  );

  // root select 1: numerators of the near and far root, near one floored
  logic signed [HB_W-1:0] hb_neg;
  logic [NUM_W-1:0]       base;
  logic [NUM_W-1:0]       s_ext;
  logic                   p1_v_r;
  logic [NUM_W-1:0]       p1_lo_r;
  logic [NUM_W-1:0]       p1_hi_r;
  logic [A_W-1:0]         p1_a_r;
  logic [THR_W-1:0]       p1_thr_r;
  logic                   p1_ok_r;

  assign hb_neg = -s_side.hb;
  assign base   = NUM_W'(hb_neg) << FB;
  assign s_ext  = NUM_W'(s_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_lo_r  <= base + ~s_ext + NUM_W'(s_exact);
      p1_hi_r  <= base + s_ext;
      p1_a_r   <= s_side.a;
      p1_thr_r <= s_side.thr;
      p1_ok_r  <= s_side.root_ok;
    end
  end

  // root select 2: quotient above min_distance iff num >= (min+1)*a,
  // saturated iff num >= a*2^DW
  logic          lo_ok;
  logic          hi_ok;
  logic          lo_sat;
  logic          hi_sat;
  logic [RW-1:0] sat_lim;

  assign sat_lim = RW'(p1_a_r) << DW;
  assign lo_ok   = !p1_lo_r[NUM_W-1] && (p1_lo_r >= NUM_W'(p1_thr_r));
  assign hi_ok   = !p1_hi_r[NUM_W-1] && (p1_hi_r >= NUM_W'(p1_thr_r));
  assign lo_sat  = RW'(p1_lo_r) >= sat_lim;
  assign hi_sat  = RW'(p1_hi_r) >= sat_lim;

  logic               p2_v_r;
  logic [RW-1:0]      p2_num_r;
  logic [A_W-1:0]     p2_a_r;
  rsi_pkg::rsi_flag_t p2_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_num_r   <= lo_ok ? RW'(p1_lo_r) : RW'(p1_hi_r);
      p2_a_r     <= p1_a_r;
      p2_f_r.hit <= p1_ok_r && (lo_ok || hi_ok);
      p2_f_r.sat <= lo_ok ? lo_sat : hi_sat;
    end
  end

  logic               d_valid;
  rsi_pkg::rsi_flag_t d_flags;
  logic [DW-1:0]      d_q;

  rsi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p2_v_r),
    .in_num    (p2_num_r),
    .in_a      (p2_a_r),
    .in_flags  (p2_f_r),
    .out_valid (d_valid),
    .out_flags (d_flags),
    .out_q     (d_q)
  );

  rsi_pkg::rsi_res_t res;

  always_comb begin
    res.hit = d_flags.hit;
    if (!d_flags.hit) begin
      res.distance = '0;
    end else if (d_flags.sat) begin
      res.distance = '1;
    end else begin
      res.distance = d_q;
    end
  end

  // output register plus one skid entry
  logic              push;
  logic              pop;
  logic              out_v_r;
  logic              out_v_nxt;
  rsi_pkg::rsi_res_t out_d_r;
  rsi_pkg::rsi_res_t out_d_nxt;
  rsi_pkg::rsi_res_t skid_d_r;
  rsi_pkg::rsi_res_t skid_d_nxt;

  assign push = en && d_valid;
  assign pop  = out_v_r && out_ch.ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!out_v_r || pop) begin
      out_v_nxt = push;
      out_d_nxt = res;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.hit          = out_d_r.hit;
  assign out_ch.hit_distance = out_d_r.distance;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a result while output register is empty");

  a_miss_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_d_r.hit |-> out_d_r.distance == '0)
    else $error("miss reported with nonzero distance");

  a_zero_dir_miss: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r && (p2_a_r == '0) |-> !p2_f_r.hit)
    else $error("zero-length direction produced a hit");
`endif

endmodule
